@@ rtl/least_loaded_dispatch_assert.svh @@
// Assertion macros for the least-loaded dispatcher and its checker.
// Stand-alone header with no dependencies; included by the checker file.
`ifndef LEAST_LOADED_DISPATCH_ASSERT_SVH
`define LEAST_LOADED_DISPATCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("least_loaded_dispatch: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define LLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("least_loaded_dispatch: next-cycle property failed");

`endif

@@ rtl/lld_pkg.sv @@
// Shared types and constants for the least-loaded dispatcher.
// No dependencies; used by every module of the block.
package lld_pkg;

    localparam int MAX_SERVERS_DEFAULT     = 32;
    localparam int TASK_LOAD_WIDTH_DEFAULT = 16;

    localparam int TASK_LOAD_BITS = 16;
    localparam int LOAD_BITS      = 32;
    localparam int INDEX_BITS     = 5;
    localparam int ACTIVE_BITS    = 6;
    localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 6'd20;

    // Servers scanned per group in the first reduction stage.
    localparam int GROUP_SIZE = 8;

    localparam int S_TDATA_BITS = 16;
    localparam int M_TDATA_BITS = 40;
    localparam int M_PAD_BITS   = M_TDATA_BITS - INDEX_BITS - LOAD_BITS;

    typedef enum logic {
        OP_ASSIGN = 1'b0,
        OP_CLEAR  = 1'b1
    } lld_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_UPDATE
    } lld_state_t;

    typedef struct packed {
        logic accept;
        logic reduce;
        logic update;
    } lld_cmd_t;

    typedef struct packed {
        logic out_free;
    } lld_stat_t;

endpackage

@@ rtl/lld_ctrl.sv @@
// Controller for the least-loaded dispatcher: sequences accept, reduce and update.
// Depends on lld_pkg for the state, command and status types.
module lld_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_ready,
    input  lld_pkg::lld_stat_t stat,
    output lld_pkg::lld_cmd_t  cmd
);

    lld_pkg::lld_state_t state_reg;
    lld_pkg::lld_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lld_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            lld_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    // A clear needs no search, so it goes straight to the update.
                    if (lld_pkg::lld_op_t'(in_op) == lld_pkg::OP_CLEAR)
                    begin
                        state_next = lld_pkg::ST_UPDATE;
                    end
                    else
                    begin
                        state_next = lld_pkg::ST_REDUCE;
                    end
                end
            end
            lld_pkg::ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = lld_pkg::ST_UPDATE;
            end
            lld_pkg::ST_UPDATE:
            begin
                if (stat.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = lld_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lld_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/lld_datapath.sv @@
// Datapath of the least-loaded dispatcher: accumulators, two-stage argmin,
// saturating add and the output register. Depends on lld_pkg.
module lld_datapath #(
    parameter int MAX_SERVERS     = lld_pkg::MAX_SERVERS_DEFAULT,
    parameter int TASK_LOAD_WIDTH = lld_pkg::TASK_LOAD_WIDTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lld_pkg::ACTIVE_BITS-1:0]     cfg_data,
    input  logic                                in_op,
    input  logic [lld_pkg::TASK_LOAD_BITS-1:0]  in_load,
    input  lld_pkg::lld_cmd_t                   cmd,
    output lld_pkg::lld_stat_t                  stat,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lld_pkg::INDEX_BITS-1:0]      out_index,
    output logic [lld_pkg::LOAD_BITS-1:0]       out_load,
    output logic                                out_sat
);

    localparam int IDX_W  = $clog2(MAX_SERVERS);
    localparam int GRP    = lld_pkg::GROUP_SIZE;
    localparam int NGRP   = (MAX_SERVERS + GRP - 1) / GRP;
    localparam int PAD    = NGRP * GRP;
    localparam int CMP_W  = lld_pkg::ACTIVE_BITS + 1;
    localparam int LW     = lld_pkg::LOAD_BITS;
    localparam int TW     = lld_pkg::TASK_LOAD_BITS;
    localparam logic [TW-1:0] TASK_MASK = (TASK_LOAD_WIDTH >= TW) ? {TW{1'b1}} :
        TW'((64'd1 << TASK_LOAD_WIDTH) - 64'd1);

    logic [lld_pkg::ACTIVE_BITS-1:0] active_reg;
    logic [LW-1:0]                   load_reg [MAX_SERVERS];

    lld_pkg::lld_op_t op_reg;
    logic [TW-1:0]    task_reg;

    logic [LW-1:0]    pad_load [PAD];
    logic [PAD-1:0]   pad_act;

    logic [LW-1:0]    grp_val_c [NGRP];
    logic [IDX_W-1:0] grp_idx_c [NGRP];
    logic [NGRP-1:0]  grp_vld_c;
    logic [LW-1:0]    grp_val_reg [NGRP];
    logic [IDX_W-1:0] grp_idx_reg [NGRP];
    logic [NGRP-1:0]  grp_vld_reg;

    logic [LW-1:0]    best_val_c;
    logic [IDX_W-1:0] best_idx_c;
    logic [LW-1:0]    best_val_reg;
    logic [IDX_W-1:0] best_idx_reg;

    logic [LW:0]      sum_c;
    logic             sat_c;
    logic [LW-1:0]    new_load_c;

    logic                           out_valid_reg;
    logic [lld_pkg::INDEX_BITS-1:0] out_index_reg;
    logic [LW-1:0]                  out_load_reg;
    logic                           out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= lld_pkg::ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            active_reg <= cfg_data;
        end
    end

    // Server 0 always takes part; a count above the server total covers them all.
    for (genvar j = 0; j < PAD; j++)
    begin : g_pad
        if (j < MAX_SERVERS)
        begin : g_real
            assign pad_load[j] = load_reg[j];
            assign pad_act[j]  = (j == 0) || ({1'b0, active_reg} > CMP_W'(j));
        end
        else
        begin : g_fill
            assign pad_load[j] = '0;
            assign pad_act[j]  = 1'b0;
        end
    end

    // First stage: a linear scan inside each group; strict compare keeps the lowest index.
    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        logic             found;
        logic [LW-1:0]    val;
        logic [IDX_W-1:0] idx;

        always_comb
        begin
            found = 1'b0;
            val   = '0;
            idx   = '0;
            for (int k = 0; k < GRP; k++)
            begin
                if (pad_act[g*GRP+k] && (!found || (pad_load[g*GRP+k] < val)))
                begin
                    found = 1'b1;
                    val   = pad_load[g*GRP+k];
                    idx   = IDX_W'(g*GRP+k);
                end
            end
        end

        assign grp_val_c[g] = val;
        assign grp_idx_c[g] = idx;
        assign grp_vld_c[g] = found;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg      <= lld_pkg::lld_op_t'(in_op);
            task_reg    <= in_load & TASK_MASK;
            grp_vld_reg <= grp_vld_c;
            for (int g = 0; g < NGRP; g++)
            begin
                grp_val_reg[g] <= grp_val_c[g];
                grp_idx_reg[g] <= grp_idx_c[g];
            end
        end
    end

    // Second stage: groups in ascending order, so ties still go to the lower index.
    always_comb
    begin
        logic found;
        found      = 1'b0;
        best_val_c = '0;
        best_idx_c = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (grp_vld_reg[g] && (!found || (grp_val_reg[g] < best_val_c)))
            begin
                found      = 1'b1;
                best_val_c = grp_val_reg[g];
                best_idx_c = grp_idx_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.reduce)
        begin
            best_val_reg <= best_val_c;
            best_idx_reg <= best_idx_c;
        end
    end

    assign sum_c      = {1'b0, best_val_reg} + (LW+1)'(task_reg);
    assign sat_c      = sum_c[LW];
    assign new_load_c = sat_c ? {LW{1'b1}} : sum_c[LW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SERVERS; i++)
            begin
                load_reg[i] <= '0;
            end
        end
        else if (cmd.update)
        begin
            if (op_reg == lld_pkg::OP_CLEAR)
            begin
                for (int i = 0; i < MAX_SERVERS; i++)
                begin
                    load_reg[i] <= '0;
                end
            end
            else
            begin
                load_reg[best_idx_reg] <= new_load_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (op_reg == lld_pkg::OP_CLEAR)
            begin
                out_index_reg <= '0;
                out_load_reg  <= '0;
                out_sat_reg   <= 1'b0;
            end
            else
            begin
                out_index_reg <= lld_pkg::INDEX_BITS'(best_idx_reg);
                out_load_reg  <= new_load_c;
                out_sat_reg   <= sat_c;
            end
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_index     = out_index_reg;
    assign out_load      = out_load_reg;
    assign out_sat       = out_sat_reg;

endmodule

@@ rtl/least_loaded_dispatch.sv @@
// Least-loaded dispatcher: sends each task to the server holding the smallest load.
// Top level; instantiates lld_ctrl and lld_datapath, uses lld_pkg.
//
// Channels: the slave stream carries tasks (tuser = operation, tdata = task load);
// the master stream returns one transaction per task (tdata = chosen server and its
// load after the add, tuser = saturation flag). The config channel writes the
// number of active servers and is always ready.
// An assign task passes through the two registered stages of the argmin search
// (groups of eight servers, then across groups); the saturating add is then written
// to the accumulator and the output register. A clear skips the search and goes
// straight to the update. No new task is taken before the current one is updated.
// Reset zeroes every accumulator, empties the output register and sets the active
// server count to 20.
// When the receiver stalls, the next task is still accepted while the result waits
// in the output register; that task then holds in its update step until the
// register frees.
module least_loaded_dispatch #(
    parameter int MAX_SERVERS     = lld_pkg::MAX_SERVERS_DEFAULT,
    parameter int TASK_LOAD_WIDTH = lld_pkg::TASK_LOAD_WIDTH_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lld_pkg::ACTIVE_BITS-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lld_pkg::S_TDATA_BITS-1:0]   s_tdata,  // [15:0] task_load
    input  logic [0:0]                         s_tuser,  // [0] operation
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lld_pkg::M_TDATA_BITS-1:0]   m_tdata,  // [4:0] server_index,
                                                         // [36:5] server_load_after,
                                                         // [39:37] zero
    output logic [0:0]                         m_tuser   // [0] saturated
);

    lld_pkg::lld_cmd_t  cmd;
    lld_pkg::lld_stat_t stat;

    logic [lld_pkg::INDEX_BITS-1:0] out_index;
    logic [lld_pkg::LOAD_BITS-1:0]  out_load;
    logic                           out_sat;

    assign cfg_ready = 1'b1;

    lld_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser[0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lld_datapath #(
        .MAX_SERVERS     (MAX_SERVERS),
        .TASK_LOAD_WIDTH (TASK_LOAD_WIDTH)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .in_op     (s_tuser[0]),
        .in_load   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (out_index),
        .out_load  (out_load),
        .out_sat   (out_sat)
    );

    assign m_tdata = {{lld_pkg::M_PAD_BITS{1'b0}}, out_load, out_index};
    assign m_tuser = out_sat;

endmodule

@@ rtl/lld_checker.sv @@
// Port-level checker for the least-loaded dispatcher, bound to the top level.
// Depends on lld_pkg and least_loaded_dispatch_assert.svh.
`include "least_loaded_dispatch_assert.svh"

module lld_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [lld_pkg::ACTIVE_BITS-1:0]    cfg_data,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [lld_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input logic [0:0]                         s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [lld_pkg::M_TDATA_BITS-1:0]   m_tdata,
    input logic [0:0]                         m_tuser
);

    // A stalled result transaction must hold its contents.
    `LLD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Only one task is in flight, so ready drops after every accepted transaction.
    `LLD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // A saturated add leaves the accumulator at its maximum.
    `LLD_ASSERT_IMPLY(a_sat_at_max, clk, rst_n, m_tvalid && m_tuser[0], m_tdata[36:5] == 32'hFFFF_FFFF)

    // The padding above the load field is always zero.
    `LLD_ASSERT_IMPLY(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[39:37] == 3'b000)

endmodule

bind least_loaded_dispatch lld_checker u_lld_checker (.*);
